// ----- hdl/fqfo_pkg.sv -----
package fqfo_pkg;

  localparam int QUEUE_SLOTS = 16;
  localparam int FRAME_BYTES = 64;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 7;
  localparam int CNT_W     = 5;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam int SLOT_W    = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int STG_AW    = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int FRM_DEPTH = QUEUE_SLOTS * FRAME_BYTES;
  localparam int FRM_AW    = (FRM_DEPTH > 1) ? $clog2(FRM_DEPTH) : 1;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CNT_W:0]    cnt_sum_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [STG_AW-1:0] stg_addr_t;
  typedef logic [FRM_AW-1:0] frm_addr_t;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_PEEK  = 2'd2,
    MODE_QUERY = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_TOOLONG = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH     = 2'd0,
    REG_LIMIT     = 2'd1,
    REG_LIFO      = 2'd2,
    REG_OVERWRITE = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_EMIT,
    ST_COPY
  } state_e;

  typedef struct packed {
    logic [1:0]  mode;
    byte_t       data_byte;
    logic        byte_last;
    len_t        read_capacity;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    byte_t       out_byte;
    len_t        frame_length;
    cnt_t        queue_count;
    logic        result_last;
  } out_t;

  typedef struct packed {
    logic      we;
    stg_addr_t waddr;
    byte_t     wdata;
    stg_addr_t raddr;
  } stg_req_t;

  typedef struct packed {
    logic  we;
    slot_t waddr;
    len_t  wdata;
    slot_t raddr;
  } len_req_t;

  typedef struct packed {
    logic      we;
    frm_addr_t waddr;
    byte_t     wdata;
    frm_addr_t raddr;
  } frm_req_t;

endpackage

// ----- hdl/fqfo_ram.sv -----
module fqfo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/fqfo_ctrl.sv -----
module fqfo_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  fqfo_pkg::in_t                   in_i,
  output logic                            busy_o,
  output logic                            res_valid_o,
  output fqfo_pkg::out_t                  res_o,
  input  logic                            cfg_we_i,
  input  logic [fqfo_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fqfo_pkg::CFG_W-1:0]      cfg_data_i,
  output fqfo_pkg::stg_req_t              stg_req_o,
  input  fqfo_pkg::byte_t                 stg_rdata_i,
  output fqfo_pkg::len_req_t              len_req_o,
  input  fqfo_pkg::len_t                  len_rdata_i,
  output fqfo_pkg::frm_req_t              frm_req_o,
  input  fqfo_pkg::byte_t                 frm_rdata_i
);

  function automatic fqfo_pkg::frm_addr_t frm_addr(input fqfo_pkg::slot_t slot,
                                                   input fqfo_pkg::stg_addr_t off);
    frm_addr = fqfo_pkg::frm_addr_t'(slot) * fqfo_pkg::frm_addr_t'(fqfo_pkg::FRAME_BYTES)
             + fqfo_pkg::frm_addr_t'(off);
  endfunction

  fqfo_pkg::state_e  state_q, state_d;
  fqfo_pkg::cnt_t    depth_q, depth_d;
  fqfo_pkg::len_t    limit_q, limit_d;
  logic              lifo_q, lifo_d;
  logic              ovw_q, ovw_d;
  fqfo_pkg::cnt_t    head_q, head_d;
  fqfo_pkg::cnt_t    held_q, held_d;
  fqfo_pkg::len_t    staged_q, staged_d;
  logic [1:0]        mode_q, mode_d;
  fqfo_pkg::len_t    cap_q, cap_d;
  fqfo_pkg::slot_t   slot_q, slot_d;
  fqfo_pkg::len_t    len_q, len_d;
  fqfo_pkg::len_t    cnt_q, cnt_d;
  logic              cpw_vld_q, cpw_vld_d;
  fqfo_pkg::stg_addr_t cpw_off_q, cpw_off_d;
  fqfo_pkg::out_t    res_q, res_d;
  logic              res_vld_q, res_vld_d;

  fqfo_pkg::cnt_t    eff_d;
  fqfo_pkg::len_t    eff_lim;
  fqfo_pkg::cnt_sum_t sum, sum_m1, eff_ext;
  fqfo_pkg::cnt_t    tail_idx, lifo_idx, rd_idx, head_inc, held_rd;
  fqfo_pkg::len_t    staged_nx, rd_len, cnt_inc, nxt_off;
  logic              accept, stg_full, too_long, q_full, cap_short, cnt_last;

  // effective configuration
  always_comb begin
    if (depth_q == '0) begin
      eff_d = fqfo_pkg::cnt_t'(1);
    end else if (int'(depth_q) > fqfo_pkg::QUEUE_SLOTS) begin
      eff_d = fqfo_pkg::cnt_t'(fqfo_pkg::QUEUE_SLOTS);
    end else begin
      eff_d = depth_q;
    end
    if (limit_q == '0) begin
      eff_lim = fqfo_pkg::len_t'(1);
    end else if (int'(limit_q) > fqfo_pkg::FRAME_BYTES) begin
      eff_lim = fqfo_pkg::len_t'(fqfo_pkg::FRAME_BYTES);
    end else begin
      eff_lim = limit_q;
    end
  end

  // ring index arithmetic, sums stay below twice the depth
  assign eff_ext  = {1'b0, eff_d};
  assign sum      = {1'b0, head_q} + {1'b0, held_q};
  assign sum_m1   = sum - fqfo_pkg::cnt_sum_t'(1);
  assign tail_idx = (sum >= eff_ext) ? fqfo_pkg::cnt_t'(sum - eff_ext) : sum[fqfo_pkg::CNT_W-1:0];
  assign lifo_idx = (sum_m1 >= eff_ext) ? fqfo_pkg::cnt_t'(sum_m1 - eff_ext)
                                        : sum_m1[fqfo_pkg::CNT_W-1:0];
  assign rd_idx   = lifo_q ? lifo_idx : head_q;
  assign head_inc = (head_q + fqfo_pkg::cnt_t'(1) == eff_d) ? '0 : head_q + fqfo_pkg::cnt_t'(1);

  assign accept    = start_i && (state_q == fqfo_pkg::ST_IDLE);
  assign stg_full  = staged_q >= fqfo_pkg::len_t'(fqfo_pkg::FRAME_BYTES);
  assign staged_nx = stg_full ? fqfo_pkg::len_t'(fqfo_pkg::FRAME_BYTES + 1)
                              : staged_q + fqfo_pkg::len_t'(1);
  assign too_long  = (staged_nx > fqfo_pkg::len_t'(fqfo_pkg::FRAME_BYTES)) ||
                     (staged_nx > eff_lim);
  assign q_full    = held_q >= eff_d;

  assign rd_len    = (len_rdata_i > fqfo_pkg::len_t'(fqfo_pkg::FRAME_BYTES))
                   ? fqfo_pkg::len_t'(fqfo_pkg::FRAME_BYTES) : len_rdata_i;
  assign cap_short = cap_q < rd_len;
  assign held_rd   = (mode_q == fqfo_pkg::MODE_POP) ? held_q - fqfo_pkg::cnt_t'(1) : held_q;
  assign cnt_inc   = cnt_q + fqfo_pkg::len_t'(1);
  assign cnt_last  = cnt_inc == len_q;
  assign nxt_off   = cnt_last ? cnt_q : cnt_inc;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fqfo_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_i.mode)
            fqfo_pkg::MODE_PUSH: begin
              if (in_i.byte_last && !too_long && (!q_full || ovw_q)) begin
                state_d = fqfo_pkg::ST_COPY;
              end
            end
            fqfo_pkg::MODE_POP, fqfo_pkg::MODE_PEEK: begin
              if (held_q != '0) begin
                state_d = fqfo_pkg::ST_LEN;
              end
            end
            default: state_d = fqfo_pkg::ST_IDLE;
          endcase
        end
      end
      fqfo_pkg::ST_LEN: begin
        if (cap_short || rd_len == '0) begin
          state_d = fqfo_pkg::ST_IDLE;
        end else begin
          state_d = fqfo_pkg::ST_EMIT;
        end
      end
      fqfo_pkg::ST_EMIT, fqfo_pkg::ST_COPY: begin
        if (cnt_last) begin
          state_d = fqfo_pkg::ST_IDLE;
        end
      end
      default: state_d = fqfo_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    depth_d   = depth_q;
    limit_d   = limit_q;
    lifo_d    = lifo_q;
    ovw_d     = ovw_q;
    head_d    = head_q;
    held_d    = held_q;
    staged_d  = staged_q;
    mode_d    = mode_q;
    cap_d     = cap_q;
    slot_d    = slot_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    cpw_vld_d = 1'b0;
    cpw_off_d = cpw_off_q;
    res_d     = '0;
    res_vld_d = 1'b0;

    stg_req_o.we    = 1'b0;
    stg_req_o.waddr = staged_q[fqfo_pkg::STG_AW-1:0];
    stg_req_o.wdata = in_i.data_byte;
    stg_req_o.raddr = cnt_q[fqfo_pkg::STG_AW-1:0];

    len_req_o.we    = 1'b0;
    len_req_o.waddr = fqfo_pkg::slot_t'(tail_idx);
    len_req_o.wdata = staged_nx;
    len_req_o.raddr = fqfo_pkg::slot_t'(rd_idx);

    frm_req_o.we    = cpw_vld_q;
    frm_req_o.waddr = frm_addr(slot_q, cpw_off_q);
    frm_req_o.wdata = stg_rdata_i;
    frm_req_o.raddr = frm_addr(slot_q, cnt_q[fqfo_pkg::STG_AW-1:0]);

    case (state_q)
      fqfo_pkg::ST_IDLE: begin
        if (accept) begin
          mode_d = in_i.mode;
          cap_d  = in_i.read_capacity;
          res_vld_d = 1'b1;
          res_d.result_last = 1'b1;
          res_d.queue_count = held_q;
          case (in_i.mode)
            fqfo_pkg::MODE_PUSH: begin
              stg_req_o.we = !stg_full;
              staged_d = staged_nx;
              if (in_i.byte_last) begin
                staged_d = '0;
                if (too_long) begin
                  res_d.status = fqfo_pkg::STAT_TOOLONG;
                end else if (q_full && !ovw_q) begin
                  res_d.status = fqfo_pkg::STAT_FULL;
                end else begin
                  len_req_o.we = 1'b1;
                  slot_d = fqfo_pkg::slot_t'(tail_idx);
                  len_d  = staged_nx;
                  cnt_d  = '0;
                  if (q_full) begin
                    head_d = head_inc;
                    held_d = eff_d;
                    res_d.queue_count = eff_d;
                  end else begin
                    held_d = held_q + fqfo_pkg::cnt_t'(1);
                    res_d.queue_count = held_q + fqfo_pkg::cnt_t'(1);
                  end
                end
              end
            end
            fqfo_pkg::MODE_POP, fqfo_pkg::MODE_PEEK: begin
              if (held_q == '0) begin
                res_d.status = fqfo_pkg::STAT_EMPTY;
              end else begin
                res_vld_d = 1'b0;
                slot_d = fqfo_pkg::slot_t'(rd_idx);
              end
            end
            default: res_d.status = fqfo_pkg::STAT_OK;
          endcase
        end
      end
      fqfo_pkg::ST_LEN: begin
        frm_req_o.raddr = frm_addr(slot_q, '0);
        cnt_d = '0;
        len_d = rd_len;
        if (cap_short) begin
          res_vld_d = 1'b1;
          res_d.status = fqfo_pkg::STAT_TOOLONG;
          res_d.queue_count = held_q;
          res_d.result_last = 1'b1;
        end else begin
          held_d = held_rd;
          if (mode_q == fqfo_pkg::MODE_POP && !lifo_q) begin
            head_d = head_inc;
          end
          if (rd_len == '0) begin
            res_vld_d = 1'b1;
            res_d.queue_count = held_rd;
            res_d.result_last = 1'b1;
          end
        end
      end
      fqfo_pkg::ST_EMIT: begin
        frm_req_o.raddr = frm_addr(slot_q, nxt_off[fqfo_pkg::STG_AW-1:0]);
        cnt_d = cnt_inc;
        res_vld_d = 1'b1;
        res_d.out_byte = frm_rdata_i;
        res_d.frame_length = len_q;
        res_d.queue_count = held_q;
        res_d.result_last = cnt_last;
      end
      fqfo_pkg::ST_COPY: begin
        cpw_vld_d = 1'b1;
        cpw_off_d = cnt_q[fqfo_pkg::STG_AW-1:0];
        cnt_d = cnt_inc;
      end
      default: res_vld_d = 1'b0;
    endcase

    if (cfg_we_i) begin
      case (cfg_idx_i)
        fqfo_pkg::REG_DEPTH: begin
          depth_d = cfg_data_i[fqfo_pkg::CNT_W-1:0];
          head_d  = '0;
          held_d  = '0;
        end
        fqfo_pkg::REG_LIMIT:     limit_d = cfg_data_i[fqfo_pkg::LEN_W-1:0];
        fqfo_pkg::REG_LIFO:      lifo_d  = cfg_data_i[0];
        fqfo_pkg::REG_OVERWRITE: ovw_d   = cfg_data_i[0];
        default: depth_d = depth_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fqfo_pkg::ST_IDLE;
      depth_q   <= fqfo_pkg::cnt_t'(16);
      limit_q   <= fqfo_pkg::len_t'(64);
      lifo_q    <= 1'b0;
      ovw_q     <= 1'b0;
      head_q    <= '0;
      held_q    <= '0;
      staged_q  <= '0;
      cnt_q     <= '0;
      len_q     <= '0;
      cpw_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      depth_q   <= depth_d;
      limit_q   <= limit_d;
      lifo_q    <= lifo_d;
      ovw_q     <= ovw_d;
      head_q    <= head_d;
      held_q    <= held_d;
      staged_q  <= staged_d;
      cnt_q     <= cnt_d;
      len_q     <= len_d;
      cpw_vld_q <= cpw_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    cap_q     <= cap_d;
    slot_q    <= slot_d;
    cpw_off_q <= cpw_off_d;
    res_q     <= res_d;
  end

  assign busy_o      = state_q != fqfo_pkg::ST_IDLE;
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

// ----- hdl/frame_queue_fifo_lifo_overwrite_core.sv -----
// Frame queue, FIFO or LIFO, with optional overwrite of the oldest frame when full.
// A request is taken when start_i is high and busy_o is low; every result appears
// on res_o for exactly one cycle with res_valid_o high, and must be taken then,
// since the receiver cannot stall the block. A push byte that does not end a frame,
// a refused push and a length query give their result in the next cycle. A committed
// push copies the staged frame into its slot one byte per cycle through the staging
// and frame memories, with busy_o high while it copies. A pop or peek reads the slot
// length, then streams the frame one byte per cycle from the frame memory; the length
// read, the frame memory read and the result register lie between the request and
// the first byte, and the next request can be taken when the last byte appears on
// res_o. A pop or peek of an empty queue answers in the next cycle like a push; a
// capacity refusal answers from the length state. Configuration writes are taken at
// any edge with cfg_we_i high and are meant for when the block is idle.
module frame_queue_fifo_lifo_overwrite_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  fqfo_pkg::in_t                   in_i,
  output logic                            busy_o,
  output logic                            res_valid_o,
  output fqfo_pkg::out_t                  res_o,
  input  logic                            cfg_we_i,
  input  logic [fqfo_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fqfo_pkg::CFG_W-1:0]      cfg_data_i
);

  fqfo_pkg::stg_req_t stg_req;
  fqfo_pkg::len_req_t len_req;
  fqfo_pkg::frm_req_t frm_req;
  fqfo_pkg::byte_t    stg_rdata;
  fqfo_pkg::len_t     len_rdata;
  fqfo_pkg::byte_t    frm_rdata;

  fqfo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .in_i        (in_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .stg_req_o   (stg_req),
    .stg_rdata_i (stg_rdata),
    .len_req_o   (len_req),
    .len_rdata_i (len_rdata),
    .frm_req_o   (frm_req),
    .frm_rdata_i (frm_rdata)
  );

  // staging buffer for the frame being pushed
  fqfo_ram #(
    .WIDTH (fqfo_pkg::BYTE_W),
    .DEPTH (fqfo_pkg::FRAME_BYTES)
  ) u_stg_ram (
    .clk_i   (clk_i),
    .we_i    (stg_req.we),
    .waddr_i (stg_req.waddr),
    .wdata_i (stg_req.wdata),
    .raddr_i (stg_req.raddr),
    .rdata_o (stg_rdata)
  );

  // length of each slot
  fqfo_ram #(
    .WIDTH (fqfo_pkg::LEN_W),
    .DEPTH (fqfo_pkg::QUEUE_SLOTS)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_req.we),
    .waddr_i (len_req.waddr),
    .wdata_i (len_req.wdata),
    .raddr_i (len_req.raddr),
    .rdata_o (len_rdata)
  );

  // frame bytes, one slot of frame size per queue entry
  fqfo_ram #(
    .WIDTH (fqfo_pkg::BYTE_W),
    .DEPTH (fqfo_pkg::FRM_DEPTH)
  ) u_frm_ram (
    .clk_i   (clk_i),
    .we_i    (frm_req.we),
    .waddr_i (frm_req.waddr),
    .wdata_i (frm_req.wdata),
    .raddr_i (frm_req.raddr),
    .rdata_o (frm_rdata)
  );

endmodule

// ----- hdl/fqfo_chk.sv -----
module fqfo_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input fqfo_pkg::in_t  in_i,
  input logic           busy_o,
  input logic           res_valid_o,
  input fqfo_pkg::out_t res_o
);

  // push and query requests answer in the next cycle with a single result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (in_i.mode == fqfo_pkg::MODE_PUSH ||
                            in_i.mode == fqfo_pkg::MODE_QUERY))
    |=> (res_valid_o && res_o.result_last))
    else $error("push or query result missing");

  // frame bytes stream without gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.result_last) |=> res_valid_o)
    else $error("gap inside frame stream");

  // an empty report means nothing is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == fqfo_pkg::STAT_EMPTY)
    |-> (res_o.queue_count == '0 && res_o.frame_length == '0))
    else $error("empty status with frames held");

  // frame bytes carry ok status and a length within the slot size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.frame_length != '0)
    |-> (res_o.status == fqfo_pkg::STAT_OK &&
         int'(res_o.frame_length) <= fqfo_pkg::FRAME_BYTES))
    else $error("bad frame byte result");

  // a streamed frame keeps one length to its end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.result_last && res_o.frame_length != '0)
    |=> $stable(res_o.frame_length))
    else $error("frame length changed inside stream");

endmodule

bind frame_queue_fifo_lifo_overwrite_core fqfo_chk u_fqfo_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .in_i        (in_i),
  .busy_o      (busy_o),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
